/* src/ppm_dec_pkg.sv */
// ----------------------------------------------------------------------------
// ppm_dec_pkg
// Shared types and constants for the pulse-position channel decoder.
// ----------------------------------------------------------------------------
package ppm_dec_pkg;

   localparam int SLOTS          = 9;
   localparam int SLOT_IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLOT_W         = 4;
   localparam int US_W           = 16;
   localparam int READ_CMP_W     = 6;
   localparam logic [US_W-1:0] PULSE_LIMIT_RESET = 16'd2100;

   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic EDGE_RISING  = 1'b0;
   localparam logic EDGE_FALLING = 1'b1;

   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;

   typedef struct packed {
      logic              cmd;
      logic [US_W-1:0]   elapsed_us;
      logic [SLOT_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic              edge_kind;
      logic [SLOT_W-1:0] slot;
      logic [US_W-1:0]   stored_value;
      logic              frame_sync;
      logic [US_W-1:0]   read_high;
      logic [US_W-1:0]   read_period;
      logic              high_valid;
      logic              period_valid;
   } rsp_type;

endpackage

/* src/ppm_channel_pulse_decoder_top.sv */
// ----------------------------------------------------------------------------
// ppm_channel_pulse_decoder_top
// Decodes an RC pulse-position train into per-slot period and high times.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per accepted cycle (req_valid high, req_stall
//   low). An edge event (cmd edge) gives the microseconds since the last
//   rising edge; edges alternate starting with a rising edge, which stores a
//   period, while a falling edge stores a high time. A read request returns
//   the stored high time and period of read_index plus the validity flags.
//   csr_write_enable / csr_write_data load the pulse limit; an interval above
//   it is a frame sync that writes zero and sends that slot index back to 0.
//   Each request yields exactly one response on rsp_*.
// Timing:
//   The response is registered: an accepted request sits in an input register,
//   then the compare and slot write feed the response register. One request per
//   cycle sustained while rsp_stall is low; the two registers form a pipe.
//   When rsp_stall holds a pending response and the input register is full,
//   req_stall rises and the input register keeps its request; nothing is lost.
// Reset:
//   synchronous; stores cleared, indexes 0, waiting for a rising edge,
//   pulse limit back to 2100, both registers empty.
// ----------------------------------------------------------------------------
module ppm_channel_pulse_decoder_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ppm_dec_pkg::req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ppm_dec_pkg::rsp_type        rsp_data,
   input  logic                        csr_write_enable,
   input  logic [ppm_dec_pkg::US_W-1:0] csr_write_data
);
   import ppm_dec_pkg::*;

   localparam slot_idx_type LAST_SLOT = SLOT_IDX_W'(SLOTS - 1);

   logic              in_valid_ff;
   req_type           in_data_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_in;
   logic [US_W-1:0]   max_pw_ff;
   logic              expect_rising_ff;
   logic              expect_rising_in;
   slot_idx_type      high_idx_ff;
   slot_idx_type      high_idx_in;
   slot_idx_type      period_idx_ff;
   slot_idx_type      period_idx_in;
   logic              high_nz_ff;
   logic              high_nz_in;
   logic              period_nz_ff;
   logic              period_nz_in;
   logic [US_W-1:0]   high_store_ff   [SLOTS];
   logic [US_W-1:0]   period_store_ff [SLOTS];

   logic              advance;
   logic              process;
   logic              is_edge;
   logic              over_limit;
   slot_idx_type      cur_idx;
   slot_idx_type      adv_idx;
   logic [US_W-1:0]   write_value;
   logic              read_in_range;
   slot_idx_type      read_idx;

   // response register drains or is empty
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign process   = in_valid_ff && advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign is_edge     = (in_data_ff.cmd == CMD_EDGE);
   assign over_limit  = in_data_ff.elapsed_us > max_pw_ff;
   assign cur_idx     = expect_rising_ff ? period_idx_ff : high_idx_ff;
   assign adv_idx     = over_limit ? '0 :
                        ((cur_idx < LAST_SLOT) ? cur_idx + 1'b1 : cur_idx);
   assign write_value = over_limit ? '0 : in_data_ff.elapsed_us;

   assign read_in_range = READ_CMP_W'(in_data_ff.read_index) < READ_CMP_W'(SLOTS);
   assign read_idx      = SLOT_IDX_W'(in_data_ff.read_index);

   always_comb begin
      expect_rising_in = expect_rising_ff;
      high_idx_in      = high_idx_ff;
      period_idx_in    = period_idx_ff;
      high_nz_in       = high_nz_ff;
      period_nz_in     = period_nz_ff;
      rsp_in           = '0;
      if (is_edge) begin
         expect_rising_in    = !expect_rising_ff;
         rsp_in.slot         = SLOT_W'(cur_idx);
         rsp_in.stored_value = write_value;
         rsp_in.frame_sync   = over_limit;
         if (expect_rising_ff) begin
            rsp_in.edge_kind = EDGE_RISING;
            period_idx_in    = adv_idx;
            // validity follows the measured value, even past the limit
            period_nz_in     = (in_data_ff.elapsed_us != '0);
         end else begin
            rsp_in.edge_kind = EDGE_FALLING;
            high_idx_in      = adv_idx;
            high_nz_in       = (in_data_ff.elapsed_us != '0);
         end
      end else if (read_in_range) begin
         rsp_in.read_high   = high_store_ff[read_idx];
         rsp_in.read_period = period_store_ff[read_idx];
      end
      rsp_in.high_valid   = high_nz_in;
      rsp_in.period_valid = period_nz_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         max_pw_ff        <= PULSE_LIMIT_RESET;
         expect_rising_ff <= 1'b1;
         high_idx_ff      <= '0;
         period_idx_ff    <= '0;
         high_nz_ff       <= 1'b0;
         period_nz_ff     <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            high_store_ff[i]   <= '0;
            period_store_ff[i] <= '0;
         end
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (csr_write_enable) begin
            max_pw_ff <= csr_write_data;
         end
         if (process) begin
            expect_rising_ff <= expect_rising_in;
            high_idx_ff      <= high_idx_in;
            period_idx_ff    <= period_idx_in;
            high_nz_ff       <= high_nz_in;
            period_nz_ff     <= period_nz_in;
            if (is_edge) begin
               if (expect_rising_ff) begin
                  period_store_ff[cur_idx] <= write_value;
               end else begin
                  high_store_ff[cur_idx] <= write_value;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
      if (process) begin
         rsp_data_ff <= rsp_in;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (high_idx_ff <= LAST_SLOT) && (period_idx_ff <= LAST_SLOT))
      else $error("slot index past last slot");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input register dropped a request while blocked");

   a_edge_toggles: assert property (@(posedge clock) disable iff (reset)
      (process && is_edge) |=> (expect_rising_ff != $past(expect_rising_ff)))
      else $error("edge polarity did not alternate");

   a_sync_zero: assert property (@(posedge clock) disable iff (reset)
      (process && is_edge && over_limit) |=>
         (rsp_data_ff.stored_value == '0) && (rsp_data_ff.slot == SLOT_W'($past(cur_idx))))
      else $error("frame sync response wrong");

endmodule
